// ----- src/trb_pkg.sv -----
// shared types, constants and helpers for the track run box parser
package trb_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned FLAGS_W     = 24;
  localparam int unsigned COUNT_W     = 17;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam logic [WORD_W-1:0] MaxSamples = 32'd65536;

  localparam int unsigned FL_OFFSET = 0;
  localparam int unsigned FL_FIRST  = 2;
  localparam int unsigned FL_DUR    = 8;
  localparam int unsigned FL_SIZE   = 9;
  localparam int unsigned FL_FLAGS  = 10;
  localparam int unsigned FL_CTO    = 11;
  localparam int unsigned NON_SYNC_BIT = 16;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_BAD   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic {
    ERR_COUNT = 1'b0,
    ERR_PLACE = 1'b1
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULTS_VALID   = 2'd0,
    CFG_DEFAULT_DURATION = 2'd1,
    CFG_DEFAULT_SIZE     = 2'd2,
    CFG_DEFAULT_FLAGS    = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_COUNT  = 4'd1,
    PH_OFFSET = 4'd2,
    PH_FIRST  = 4'd3,
    PH_DUR    = 4'd4,
    PH_SIZE   = 4'd5,
    PH_FLAGS  = 4'd6,
    PH_CTO    = 4'd7,
    PH_STEP   = 4'd8,
    PH_END    = 4'd9
  } phase_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     error_code;
    logic [COUNT_W-1:0]       sample_count;
    logic signed [WORD_W-1:0] data_offset;
    logic                     offset_present;
    logic [INDEX_W-1:0]       sample_index;
    logic [WORD_W-1:0]        duration;
    logic [WORD_W-1:0]        size_bytes;
    logic [WORD_W-1:0]        sample_flags;
    logic [WORD_W-1:0]        composition_offset;
    logic                     last;
  } rec_t;

  // first sample field present at or after p
  function automatic phase_t next_field(phase_t p, logic [FLAGS_W-1:0] f);
    phase_t r;
    r = PH_END;
    if (p <= PH_CTO && f[FL_CTO]) r = PH_CTO;
    if (p <= PH_FLAGS && f[FL_FLAGS] && !f[FL_FIRST]) r = PH_FLAGS;
    if (p <= PH_SIZE && f[FL_SIZE]) r = PH_SIZE;
    if (p <= PH_DUR && f[FL_DUR]) r = PH_DUR;
    return r;
  endfunction

  function automatic phase_t sample_start(logic [FLAGS_W-1:0] f);
    phase_t p;
    p = next_field(PH_DUR, f);
    return (p == PH_END) ? PH_STEP : p;
  endfunction

endpackage

// ----- src/trb_if.sv -----
// stream interfaces for box words in and parsed records out
interface trb_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [trb_pkg::WORD_W-1:0]   word;

  modport source (output valid, output req_type, output word, input ready);
  modport sink   (input valid, input req_type, input word, output ready);
endinterface

interface trb_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic                                error_code;
  logic [trb_pkg::COUNT_W-1:0]         sample_count;
  logic signed [trb_pkg::WORD_W-1:0]   data_offset;
  logic                                offset_present;
  logic [trb_pkg::INDEX_W-1:0]         sample_index;
  logic [trb_pkg::WORD_W-1:0]          duration;
  logic [trb_pkg::WORD_W-1:0]          size_bytes;
  logic [trb_pkg::WORD_W-1:0]          sample_flags;
  logic [trb_pkg::WORD_W-1:0]          composition_offset;
  logic                                last;

  modport source (output valid, output kind, output error_code, output sample_count,
                  output data_offset, output offset_present, output sample_index,
                  output duration, output size_bytes, output sample_flags,
                  output composition_offset, output last, input ready);
  modport sink   (input valid, input kind, input error_code, input sample_count,
                  input data_offset, input offset_present, input sample_index,
                  input duration, input size_bytes, input sample_flags,
                  input composition_offset, input last, output ready);
endinterface

// ----- src/track_run_box_parser_top.sv -----
// track run box parser: box words in, header, sample and error records out
//
//   port     direction  transaction
//   in_if    sink       one box word or step item (req_type, word)
//   out_if   source     one header, sample or error record
//   cfg_*    write      one default register write
//
// one input transaction per cycle unless stalled; its record, if any, is registered
// output register plus one skid entry, so input stalls only when both are full
// rst_n is synchronous, active low; it clears phase, defaults and both record slots
module track_run_box_parser_top (
  input  logic                            clk,
  input  logic                            rst_n,
  trb_in_if.sink                          in_if,
  trb_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [trb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trb_pkg::WORD_W-1:0]      cfg_wdata
);
  import trb_pkg::*;

  logic                dv_r;
  logic [WORD_W-1:0]   def_dur_r;
  logic [WORD_W-1:0]   def_size_r;
  logic [WORD_W-1:0]   def_flags_r;

  phase_t              phase_r, phase_nxt;
  logic [FLAGS_W-1:0]  flags_r, flags_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [INDEX_W-1:0]  index_r, index_nxt;
  logic [WORD_W-1:0]   offset_r, offset_nxt;
  logic [WORD_W-1:0]   first_r, first_nxt;
  logic [WORD_W-1:0]   pdur_r, pdur_nxt;
  logic [WORD_W-1:0]   psize_r, psize_nxt;
  logic [WORD_W-1:0]   pflags_r, pflags_nxt;

  logic                out_valid_r, skid_valid_r;
  rec_t                out_rec_r, skid_rec_r;

  logic                accept;
  logic                res_valid;
  rec_t                res;
  logic                do_header, do_sample, do_error;
  err_t                err_code;
  logic [WORD_W-1:0]   cto;
  logic                fin;
  logic                out_free;

  assign in_if.ready = !skid_valid_r;
  assign accept      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= 1'b0;
      def_dur_r   <= '0;
      def_size_r  <= '0;
      def_flags_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DEFAULTS_VALID:   dv_r        <= cfg_wdata[0];
        CFG_DEFAULT_DURATION: def_dur_r   <= cfg_wdata;
        CFG_DEFAULT_SIZE:     def_size_r  <= cfg_wdata;
        CFG_DEFAULT_FLAGS:    def_flags_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parse step
  always_comb begin
    phase_nxt  = phase_r;
    flags_nxt  = flags_r;
    count_nxt  = count_r;
    index_nxt  = index_r;
    offset_nxt = offset_r;
    first_nxt  = first_r;
    pdur_nxt   = pdur_r;
    psize_nxt  = psize_r;
    pflags_nxt = pflags_r;
    do_header  = 1'b0;
    do_sample  = 1'b0;
    do_error   = 1'b0;
    err_code   = ERR_PLACE;
    cto        = '0;
    fin        = 1'b0;
    res        = '0;

    if (accept) begin
      case (req_t'(in_if.req_type))
        REQ_START: begin
          if (phase_r != PH_IDLE) begin
            do_error = 1'b1;
          end else begin
            flags_nxt = in_if.word[FLAGS_W-1:0];
            phase_nxt = PH_COUNT;
          end
        end
        REQ_STEP: begin
          if (phase_r != PH_STEP) do_error = 1'b1;
          else do_sample = 1'b1;
        end
        REQ_DATA: begin
          case (phase_r)
            PH_COUNT: begin
              if (in_if.word > MaxSamples) begin
                do_error = 1'b1;
                err_code = ERR_COUNT;
              end else begin
                count_nxt = in_if.word[COUNT_W-1:0];
                if (flags_r[FL_OFFSET]) phase_nxt = PH_OFFSET;
                else if (flags_r[FL_FIRST]) phase_nxt = PH_FIRST;
                else do_header = 1'b1;
              end
            end
            PH_OFFSET: begin
              offset_nxt = in_if.word;
              if (flags_r[FL_FIRST]) phase_nxt = PH_FIRST;
              else do_header = 1'b1;
            end
            PH_FIRST: begin
              first_nxt = in_if.word;
              do_header = 1'b1;
            end
            PH_DUR: begin
              pdur_nxt  = in_if.word;
              phase_nxt = next_field(PH_SIZE, flags_r);
              if (phase_nxt == PH_END) do_sample = 1'b1;
            end
            PH_SIZE: begin
              psize_nxt = in_if.word;
              phase_nxt = next_field(PH_FLAGS, flags_r);
              if (phase_nxt == PH_END) do_sample = 1'b1;
            end
            PH_FLAGS: begin
              pflags_nxt = in_if.word;
              phase_nxt  = next_field(PH_CTO, flags_r);
              if (phase_nxt == PH_END) do_sample = 1'b1;
            end
            PH_CTO: begin
              cto       = in_if.word;
              do_sample = 1'b1;
            end
            default: do_error = 1'b1;
          endcase
        end
        default: do_error = 1'b1;
      endcase

      if (do_error) begin
        res.kind       = KIND_ERROR;
        res.error_code = err_code;
        res.last       = 1'b1;
        phase_nxt      = PH_IDLE;
      end else if (do_header) begin
        res.kind           = KIND_HEADER;
        res.sample_count   = count_nxt;
        res.data_offset    = flags_r[FL_OFFSET] ? offset_nxt : '0;
        res.offset_present = flags_r[FL_OFFSET];
        res.last           = (count_nxt == '0);
        index_nxt          = '0;
        phase_nxt          = (count_nxt == '0) ? PH_IDLE : sample_start(flags_r);
      end else if (do_sample) begin
        fin                = ({1'b0, index_r} + 1'b1) >= count_r;
        res.kind           = KIND_SAMPLE;
        res.sample_index   = index_r;
        res.duration       = flags_r[FL_DUR] ? pdur_nxt : (dv_r ? def_dur_r : '0);
        res.size_bytes     = flags_r[FL_SIZE] ? psize_nxt : (dv_r ? def_size_r : '0);
        if (flags_r[FL_FIRST]) begin
          res.sample_flags = first_r;
          res.sample_flags[NON_SYNC_BIT] = first_r[NON_SYNC_BIT] || (index_r != '0);
        end else if (flags_r[FL_FLAGS]) begin
          res.sample_flags = pflags_nxt;
        end else begin
          res.sample_flags = dv_r ? def_flags_r : '0;
        end
        res.composition_offset = cto;
        res.last               = fin;
        if (fin) begin
          phase_nxt = PH_IDLE;
        end else begin
          index_nxt = index_r + 1'b1;
          phase_nxt = sample_start(flags_r);
        end
      end
    end
  end

  assign res_valid = do_error || do_header || do_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      flags_r <= '0;
      count_r <= '0;
      index_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      count_r <= count_nxt;
      index_r <= index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r <= offset_nxt;
    first_r  <= first_nxt;
    pdur_r   <= pdur_nxt;
    psize_r  <= psize_nxt;
    pflags_r <= pflags_nxt;
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) out_rec_r <= skid_rec_r;
      else if (res_valid) out_rec_r <= res;
    end else if (res_valid) begin
      skid_rec_r <= res;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.kind               = out_rec_r.kind;
  assign out_if.error_code         = out_rec_r.error_code;
  assign out_if.sample_count       = out_rec_r.sample_count;
  assign out_if.data_offset        = out_rec_r.data_offset;
  assign out_if.offset_present     = out_rec_r.offset_present;
  assign out_if.sample_index       = out_rec_r.sample_index;
  assign out_if.duration           = out_rec_r.duration;
  assign out_if.size_bytes         = out_rec_r.size_bytes;
  assign out_if.sample_flags       = out_rec_r.sample_flags;
  assign out_if.composition_offset = out_rec_r.composition_offset;
  assign out_if.last               = out_rec_r.last;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rec_r.kind == KIND_ERROR) |-> out_rec_r.last)
    else $error("error record without last");

  a_error_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && do_error) |=> (phase_r == PH_IDLE))
    else $error("parser not idle after error");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_valid && res.last) |=> (phase_r == PH_IDLE))
    else $error("parser not idle after final record");
`endif

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the track run box parser: directed, stall and random runs
module tb;
  import trb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  trb_in_if  in_if ();
  trb_out_if out_if ();

  track_run_box_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // parser state mirror
  phase_t       rb_phase   = PH_IDLE;
  logic [7:0]   rb_version = '0;
  logic [23:0]  rb_flags   = '0;
  logic [16:0]  rb_count   = '0;
  logic [15:0]  rb_index   = '0;
  logic [31:0]  rb_offset  = '0;
  logic [31:0]  rb_first   = '0;
  logic [31:0]  rb_dur     = '0;
  logic [31:0]  rb_size    = '0;
  logic [31:0]  rb_sflags  = '0;

  // default registers mirror
  logic         dflt_on    = 1'b0;
  logic [31:0]  dflt_dur   = '0;
  logic [31:0]  dflt_size  = '0;
  logic [31:0]  dflt_flags = '0;

  rec_t due_records[$];
  int   failures   = 0;
  int   items_sent = 0;
  int   hold_len   = 0;
  bit   tx_idle    = 1'b1;
  bit   rx_idle    = 1'b1;

  function automatic bit field_on(phase_t p);
    case (p)
      PH_DUR:   return rb_flags[FL_DUR];
      PH_SIZE:  return rb_flags[FL_SIZE];
      PH_FLAGS: return rb_flags[FL_FLAGS] && !rb_flags[FL_FIRST];
      PH_CTO:   return rb_flags[FL_CTO];
      default:  return 1'b0;
    endcase
  endfunction

  function automatic phase_t field_after(int p);
    for (int q = p; q <= int'(PH_CTO); q++) begin
      if (field_on(phase_t'(q))) return phase_t'(q);
    end
    return PH_END;
  endfunction

  function automatic void open_sample();
    phase_t p;
    p = field_after(int'(PH_DUR));
    rb_phase = (p == PH_END) ? PH_STEP : p;
  endfunction

  function automatic rec_t error_rec(err_t code);
    rec_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    r.last = 1'b1;
    rb_phase = PH_IDLE;
    return r;
  endfunction

  function automatic rec_t header_rec();
    rec_t r;
    r = '0;
    r.kind = KIND_HEADER;
    r.sample_count = rb_count;
    r.data_offset = rb_flags[FL_OFFSET] ? rb_offset : '0;
    r.offset_present = rb_flags[FL_OFFSET];
    r.last = (rb_count == 0);
    rb_index = '0;
    if (rb_count == 0) rb_phase = PH_IDLE;
    else open_sample();
    return r;
  endfunction

  function automatic rec_t sample_rec(logic [31:0] cto);
    rec_t r;
    bit   fin;
    fin = ({16'b0, rb_index} + 32'd1) >= {15'b0, rb_count};
    r = '0;
    r.kind = KIND_SAMPLE;
    r.sample_index = rb_index;
    r.duration = rb_flags[FL_DUR] ? rb_dur : (dflt_on ? dflt_dur : '0);
    r.size_bytes = rb_flags[FL_SIZE] ? rb_size : (dflt_on ? dflt_size : '0);
    if (rb_flags[FL_FIRST])
      r.sample_flags = rb_first | ((rb_index > 0) ? (32'd1 << NON_SYNC_BIT) : 32'd0);
    else if (rb_flags[FL_FLAGS])
      r.sample_flags = rb_sflags;
    else
      r.sample_flags = dflt_on ? dflt_flags : '0;
    r.composition_offset = cto;
    r.last = fin;
    if (fin) begin
      rb_phase = PH_IDLE;
    end else begin
      rb_index++;
      open_sample();
    end
    return r;
  endfunction

  // returns one when the accepted item yields a record
  function automatic bit parse_word(input logic [1:0] req, input logic [31:0] w,
                                    output rec_t r);
    phase_t nx;
    r = '0;
    if (req == REQ_START) begin
      if (rb_phase != PH_IDLE) begin
        r = error_rec(ERR_PLACE);
        return 1'b1;
      end
      rb_version = w[31:24];
      rb_flags = w[23:0];
      rb_phase = PH_COUNT;
      return 1'b0;
    end
    if (req == REQ_STEP) begin
      if (rb_phase != PH_STEP) r = error_rec(ERR_PLACE);
      else r = sample_rec('0);
      return 1'b1;
    end
    if (req != REQ_DATA || rb_phase == PH_IDLE || rb_phase == PH_STEP || rb_phase > PH_CTO) begin
      r = error_rec(ERR_PLACE);
      return 1'b1;
    end
    case (rb_phase)
      PH_COUNT: begin
        if (w > MaxSamples) begin
          r = error_rec(ERR_COUNT);
          return 1'b1;
        end
        rb_count = w[16:0];
        if (rb_flags[FL_OFFSET]) begin
          rb_phase = PH_OFFSET;
          return 1'b0;
        end
        if (rb_flags[FL_FIRST]) begin
          rb_phase = PH_FIRST;
          return 1'b0;
        end
        r = header_rec();
        return 1'b1;
      end
      PH_OFFSET: begin
        rb_offset = w;
        if (rb_flags[FL_FIRST]) begin
          rb_phase = PH_FIRST;
          return 1'b0;
        end
        r = header_rec();
        return 1'b1;
      end
      PH_FIRST: begin
        rb_first = w;
        r = header_rec();
        return 1'b1;
      end
      PH_CTO: begin
        r = sample_rec(w);
        return 1'b1;
      end
      default: begin
        if (rb_phase == PH_DUR) rb_dur = w;
        else if (rb_phase == PH_SIZE) rb_size = w;
        else rb_sflags = w;
        nx = field_after(int'(rb_phase) + 1);
        if (nx == PH_END) begin
          r = sample_rec('0);
          return 1'b1;
        end
        rb_phase = nx;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] req, input logic [31:0] w);
    int   gap;
    rec_t r;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.word <= w;
    do @(posedge clk); while (!in_if.ready);
    if (parse_word(req, w, r)) due_records.insert(due_records.size(), r);
    items_sent++;
  endtask

  task automatic stray_item(input int noise);
    if ($urandom_range(0, 99) < noise) send_item(2'($urandom_range(0, 3)), $urandom);
  endtask

  task automatic wait_drained(input int settle);
    in_if.valid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_DEFAULTS_VALID:   dflt_on = v[0];
      CFG_DEFAULT_DURATION: dflt_dur = v;
      CFG_DEFAULT_SIZE:     dflt_size = v;
      CFG_DEFAULT_FLAGS:    dflt_flags = v;
      default: ;
    endcase
  endtask

  task automatic set_defaults(input logic [31:0] on_word, input logic [31:0] dur,
                              input logic [31:0] size, input logic [31:0] flags);
    cfg_write(CFG_DEFAULTS_VALID, on_word);
    cfg_write(CFG_DEFAULT_DURATION, dur);
    cfg_write(CFG_DEFAULT_SIZE, size);
    cfg_write(CFG_DEFAULT_FLAGS, flags);
    cfg_we <= 1'b0;
  endtask

  // one well-formed run, optionally cut short or salted with stray items
  task automatic run_box(input logic [7:0] ver, input logic [23:0] fl, input logic [31:0] cnt,
                         input int nsend, input int noise);
    bit wordless;
    wordless = !(fl[FL_DUR] || fl[FL_SIZE] || (fl[FL_FLAGS] && !fl[FL_FIRST]) || fl[FL_CTO]);
    send_item(REQ_START, {ver, fl});
    stray_item(noise);
    send_item(REQ_DATA, cnt);
    if (cnt > MaxSamples) return;
    if (fl[FL_OFFSET]) send_item(REQ_DATA, pick_word());
    if (fl[FL_FIRST]) send_item(REQ_DATA, pick_word());
    for (int s = 0; s < nsend && s < cnt; s++) begin
      stray_item(noise);
      if (fl[FL_DUR]) send_item(REQ_DATA, pick_word());
      if (fl[FL_SIZE]) send_item(REQ_DATA, pick_word());
      if (fl[FL_FLAGS] && !fl[FL_FIRST]) send_item(REQ_DATA, pick_word());
      if (fl[FL_CTO]) send_item(REQ_DATA, pick_word());
      if (wordless) send_item(REQ_STEP, $urandom);
    end
  endtask

  task automatic test_directed_runs();
    // empty run
    send_item(REQ_START, {8'h00, 24'h000000});
    send_item(REQ_DATA, 32'd0);
    // every optional field, first-sample flags override per-sample flags
    send_item(REQ_START, {8'hFF, 24'hFFFFFF});
    send_item(REQ_DATA, 32'd1);
    send_item(REQ_DATA, 32'h8000_0000);
    send_item(REQ_DATA, 32'hFFFF_FFFF);
    send_item(REQ_DATA, 32'hFFFF_FFFF);
    send_item(REQ_DATA, 32'h0000_0000);
    send_item(REQ_DATA, 32'hFFFF_FFFF);
    // wordless samples stepped, non-sync on later samples
    send_item(REQ_START, {8'h01, 24'h000004});
    send_item(REQ_DATA, 32'd3);
    send_item(REQ_DATA, 32'h0000_0040);
    repeat (3) send_item(REQ_STEP, 32'h0);
  endtask

  task automatic test_directed_errors();
    send_item(REQ_DATA, 32'h1);
    send_item(REQ_STEP, 32'h0);
    send_item(REQ_BAD, 32'hFFFF_FFFF);
    send_item(REQ_START, {8'h00, 24'h000000});
    send_item(REQ_DATA, MaxSamples + 32'd1);
    send_item(REQ_START, {8'h00, 24'h000000});
    send_item(REQ_DATA, 32'hFFFF_FFFF);
    // largest legal count, then a start word mid run
    send_item(REQ_START, {8'h00, 24'h000100});
    send_item(REQ_DATA, MaxSamples);
    send_item(REQ_START, {8'h00, 24'h000000});
    // step where a duration word is due
    send_item(REQ_START, {8'h00, 24'h000100});
    send_item(REQ_DATA, 32'd1);
    send_item(REQ_STEP, 32'h0);
    // data word where a step is due
    send_item(REQ_START, {8'h00, 24'h000000});
    send_item(REQ_DATA, 32'd1);
    send_item(REQ_DATA, 32'h1234_5678);
  endtask

  task automatic test_default_settings();
    for (int k = 0; k < 4; k++) begin
      wait_drained(4);
      case (k)
        0: set_defaults(32'h1, '1, '1, '1);
        1: set_defaults(32'hFFFF_FFFF, '0, '0, '0);
        2: set_defaults(32'hFFFF_FFFE, $urandom, $urandom, $urandom);
        default: set_defaults(32'h1, $urandom, $urandom, $urandom);
      endcase
      run_box(8'($urandom), 24'h000000, 32'd2, 2, 0);
      run_box(8'($urandom), 24'($urandom), 32'd2, 2, 0);
    end
  endtask

  task automatic test_backpressure();
    wait_drained(4);
    tx_idle = 1'b0;
    hold_len = 300;
    run_box(8'h00, 24'h000000, 32'd60, 60, 0);
    wait_drained(4);
    tx_idle = 1'b1;
  endtask

  task automatic test_sender_pause();
    run_box(8'($urandom), 24'h000F01, 32'd4, 4, 0);
    wait_drained(1);
    run_box(8'($urandom), 24'h000305, 32'd4, 4, 0);
  endtask

  task automatic test_random_runs(input int target);
    int          pick;
    int          nsend;
    int          noise;
    logic [31:0] cnt;
    logic [23:0] fl;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 15) begin
        tx_idle = $urandom_range(0, 1);
        rx_idle = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 99) < 8) begin
        wait_drained(4);
        set_defaults($urandom, pick_word(), pick_word(), pick_word());
      end
      fl = 24'($urandom);
      if ($urandom_range(0, 3) == 0) fl[11:8] = 4'b0;
      pick = $urandom_range(0, 99);
      if (pick < 60) cnt = $urandom_range(0, 4);
      else if (pick < 92) cnt = $urandom_range(5, 24);
      else if (pick < 95) cnt = MaxSamples;
      else if (pick < 98) cnt = $urandom_range(32'd65537, 32'hFFFF_FFFF);
      else cnt = $urandom_range(25, 120);
      if (cnt > MaxSamples) nsend = 0;
      else if (cnt == MaxSamples || $urandom_range(0, 19) == 0) nsend = $urandom_range(0, 3);
      else nsend = int'(cnt);
      noise = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 20) : 0;
      run_box(8'($urandom), fl, cnt, nsend, noise);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  // record checker
  always @(posedge clk) begin
    rec_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_records.size() == 0) begin
        $display("%0t unexpected record expected none actual kind %0d", $time, out_if.kind);
        failures++;
      end else begin
        want = due_records.pop_front();
        check_field("kind", want.kind, out_if.kind);
        check_field("error_code", want.error_code, out_if.error_code);
        check_field("sample_count", want.sample_count, out_if.sample_count);
        check_field("data_offset", want.data_offset, out_if.data_offset);
        check_field("offset_present", want.offset_present, out_if.offset_present);
        check_field("sample_index", want.sample_index, out_if.sample_index);
        check_field("duration", want.duration, out_if.duration);
        check_field("size_bytes", want.size_bytes, out_if.size_bytes);
        check_field("sample_flags", want.sample_flags, out_if.sample_flags);
        check_field("composition_offset", want.composition_offset, out_if.composition_offset);
        check_field("last", want.last, out_if.last);
      end
    end
  end

  // record receiver with random stalls and long hold-offs
  initial begin
    int stall;
    int held;
    out_if.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        held = hold_len;
        hold_len = 0;
        out_if.ready <= 1'b0;
        repeat (held) @(posedge clk);
      end
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_START;
    in_if.word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DEFAULTS_VALID;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_runs();
    test_directed_errors();
    test_default_settings();
    test_backpressure();
    test_sender_pause();
    test_random_runs(850);
    wait_drained(20);
    if (failures == 0 && due_records.size() == 0) begin
      $display("track_run_box_parser_top verification clean");
    end else begin
      $display("track_run_box_parser_top verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("track_run_box_parser_top verification failed");
    $finish;
  end

endmodule
